@@ hdl/assert_macros.svh @@
// assertion macros used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property checked on every aclk edge outside reset
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// implication checked on every aclk edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/adsr_pkg.sv @@
// types, constants and microcode table of the adsr envelope generator
`default_nettype none

package adsr_pkg;

    localparam int TIME_BITS      = 24;
    localparam int ELAPSED_BITS   = TIME_BITS + 1;
    localparam int LEVEL_BITS     = 16;
    localparam int FULL_SCALE     = 32768;
    localparam int QBITS          = LEVEL_BITS + 1;
    localparam int PROD_BITS      = ELAPSED_BITS + LEVEL_BITS;
    localparam int CNT_BITS       = $clog2(QBITS);
    localparam int UPC_BITS       = 3;
    localparam int KIND_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
    localparam int TIME_RESET     = 4800;
    localparam int SUSTAIN_RESET  = 16384;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_TICK  = 2'd0,
        KIND_ON    = 2'd1,
        KIND_OFF   = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_DECAY   = 2'd1,
        CFG_SUSTAIN = 2'd2,
        CFG_RELEASE = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        UOP_FETCH    = 3'd0,
        UOP_SEL      = 3'd1,
        UOP_MUL      = 3'd2,
        UOP_DIV_INIT = 3'd3,
        UOP_DIV_STEP = 3'd4,
        UOP_LEVEL    = 3'd5,
        UOP_ADV      = 3'd6,
        UOP_OUT      = 3'd7
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_NO_REQ   = 3'd1,
        COND_NO_DIV   = 3'd2,
        COND_CNT_NZ   = 3'd3,
        COND_OUT_BUSY = 3'd4
    } cond_t;

    typedef struct packed {
        uop_t                op;
        cond_t               cond;
        logic [UPC_BITS-1:0] target;
    } uword_t;

    localparam logic [UPC_BITS-1:0] STEP_FETCH    = 3'd0;
    localparam logic [UPC_BITS-1:0] STEP_SEL      = 3'd1;
    localparam logic [UPC_BITS-1:0] STEP_MUL      = 3'd2;
    localparam logic [UPC_BITS-1:0] STEP_DIV_INIT = 3'd3;
    localparam logic [UPC_BITS-1:0] STEP_DIV_STEP = 3'd4;
    localparam logic [UPC_BITS-1:0] STEP_LEVEL    = 3'd5;
    localparam logic [UPC_BITS-1:0] STEP_ADV      = 3'd6;
    localparam logic [UPC_BITS-1:0] STEP_OUT      = 3'd7;

    typedef struct packed {
        logic fetch;
        logic sel;
        logic mul;
        logic div_init;
        logic div_step;
        logic level;
        logic adv;
        logic out;
    } dp_ctrl_t;

    typedef struct packed {
        logic req;
        logic no_div;
        logic cnt_nz;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  attack_time;
        logic [TIME_BITS-1:0]  decay_time;
        logic [LEVEL_BITS-1:0] sustain_level;
        logic [TIME_BITS-1:0]  release_time;
    } cfg_t;

    // microprogram: jump to target when the condition holds, else step on
    // (the last step wraps to fetch)
    function automatic uword_t urom(input logic [UPC_BITS-1:0] addr);
        uword_t w;
        begin
            case (addr)
                STEP_FETCH:    w = '{UOP_FETCH,    COND_NO_REQ,   STEP_FETCH};
                STEP_SEL:      w = '{UOP_SEL,      COND_NO_DIV,   STEP_LEVEL};
                STEP_MUL:      w = '{UOP_MUL,      COND_NEXT,     STEP_FETCH};
                STEP_DIV_INIT: w = '{UOP_DIV_INIT, COND_NEXT,     STEP_FETCH};
                STEP_DIV_STEP: w = '{UOP_DIV_STEP, COND_CNT_NZ,   STEP_DIV_STEP};
                STEP_LEVEL:    w = '{UOP_LEVEL,    COND_NEXT,     STEP_FETCH};
                STEP_ADV:      w = '{UOP_ADV,      COND_NEXT,     STEP_FETCH};
                STEP_OUT:      w = '{UOP_OUT,      COND_OUT_BUSY, STEP_OUT};
                default:       w = '{UOP_FETCH,    COND_NO_REQ,   STEP_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/adsr_cfg.sv @@
// configuration registers with write filtering
`default_nettype none

module adsr_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output adsr_pkg::cfg_t                          cfg
);

    adsr_pkg::cfg_t                   cfg_reg;
    adsr_pkg::cfg_t                   cfg_next;
    logic [adsr_pkg::TIME_BITS-1:0]  wr_time;
    logic [adsr_pkg::LEVEL_BITS-1:0] wr_level;

    assign wr_time  = cfg_data[adsr_pkg::TIME_BITS-1:0];
    assign wr_level = cfg_data[adsr_pkg::LEVEL_BITS-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            // zero times and sustain above full scale are dropped
            unique case (cfg_index)
                adsr_pkg::CFG_ATTACK: begin
                    if (wr_time != '0) cfg_next.attack_time = wr_time;
                end
                adsr_pkg::CFG_DECAY: begin
                    if (wr_time != '0) cfg_next.decay_time = wr_time;
                end
                adsr_pkg::CFG_SUSTAIN: begin
                    if (wr_level <= adsr_pkg::LEVEL_BITS'(adsr_pkg::FULL_SCALE))
                        cfg_next.sustain_level = wr_level;
                end
                adsr_pkg::CFG_RELEASE: begin
                    if (wr_time != '0) cfg_next.release_time = wr_time;
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_time   <= adsr_pkg::TIME_BITS'(adsr_pkg::TIME_RESET);
            cfg_reg.decay_time    <= adsr_pkg::TIME_BITS'(adsr_pkg::TIME_RESET);
            cfg_reg.sustain_level <= adsr_pkg::LEVEL_BITS'(adsr_pkg::SUSTAIN_RESET);
            cfg_reg.release_time  <= adsr_pkg::TIME_BITS'(adsr_pkg::TIME_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/adsr_seq.sv @@
// microcode sequencer: step counter, control rom and jump logic
`default_nettype none

module adsr_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire adsr_pkg::dp_stat_t stat,
    output adsr_pkg::dp_ctrl_t     ctrl
);

    logic [adsr_pkg::UPC_BITS-1:0] upc_reg;
    logic [adsr_pkg::UPC_BITS-1:0] upc_next;
    adsr_pkg::uword_t              word;
    logic                          take_jump;

    assign word = adsr_pkg::urom(upc_reg);

    always_comb begin
        unique case (word.cond)
            adsr_pkg::COND_NEXT:     take_jump = 1'b0;
            adsr_pkg::COND_NO_REQ:   take_jump = !stat.req;
            adsr_pkg::COND_NO_DIV:   take_jump = stat.no_div;
            adsr_pkg::COND_CNT_NZ:   take_jump = stat.cnt_nz;
            adsr_pkg::COND_OUT_BUSY: take_jump = stat.out_busy;
            default:                 take_jump = 1'b0;
        endcase
        upc_next = take_jump ? word.target : upc_reg + 1'b1;
    end

    always_comb begin
        ctrl = '0;
        unique case (word.op)
            adsr_pkg::UOP_FETCH:    ctrl.fetch    = 1'b1;
            adsr_pkg::UOP_SEL:      ctrl.sel      = 1'b1;
            adsr_pkg::UOP_MUL:      ctrl.mul      = 1'b1;
            adsr_pkg::UOP_DIV_INIT: ctrl.div_init = 1'b1;
            adsr_pkg::UOP_DIV_STEP: ctrl.div_step = 1'b1;
            adsr_pkg::UOP_LEVEL:    ctrl.level    = 1'b1;
            adsr_pkg::UOP_ADV:      ctrl.adv      = 1'b1;
            adsr_pkg::UOP_OUT:      ctrl.out      = 1'b1;
            default:                ctrl          = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= adsr_pkg::STEP_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/adsr_dp.sv @@
// envelope datapath: phase state, multiplier, serial divider and output register
`default_nettype none

`include "assert_macros.svh"

module adsr_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire adsr_pkg::dp_ctrl_t                  ctrl,
    output adsr_pkg::dp_stat_t                       stat,
    input  wire adsr_pkg::cfg_t                      cfg,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [adsr_pkg::KIND_BITS-1:0]      s_kind,
    input  wire logic [adsr_pkg::TIME_BITS-1:0]      s_delta_time,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [adsr_pkg::LEVEL_BITS-1:0]          m_level,
    output logic                                     m_sounding
);

    localparam int EB = adsr_pkg::ELAPSED_BITS;
    localparam int TB = adsr_pkg::TIME_BITS;
    localparam int LB = adsr_pkg::LEVEL_BITS;
    localparam int QB = adsr_pkg::QBITS;
    localparam int PB = adsr_pkg::PROD_BITS;

    adsr_pkg::phase_t   phase_reg, phase_next;
    logic [EB-1:0]      e_reg, e_next;
    logic [TB-1:0]      delta_reg;
    logic [LB-1:0]      mulk_reg;
    logic [TB-1:0]      den_reg;
    logic [PB-1:0]      prod_reg;
    logic [TB-1:0]      rem_reg;
    logic [QB-1:0]      lo_reg;
    logic [QB-1:0]      quo_reg;
    logic               sat_reg;
    logic [adsr_pkg::CNT_BITS-1:0] cnt_reg;
    logic [LB-1:0]      level_reg;
    logic               m_valid_reg;
    logic [LB-1:0]      m_level_reg;
    logic               m_sounding_reg;

    logic [PB-1:0]      prod_c;
    logic [TB-1:0]      prod_hi;
    logic [TB:0]        rem_try;
    logic               rem_ge;
    logic [TB:0]        rem_sub;
    logic [LB-1:0]      qsat;
    logic [LB-1:0]      level_c;
    logic [EB:0]        esum;
    logic [EB-1:0]      esat;
    logic               out_busy;

    assign out_busy = m_valid_reg && !m_ready;
    assign s_ready  = ctrl.fetch;

    assign stat.req      = s_valid;
    assign stat.no_div   = (phase_reg == adsr_pkg::PH_IDLE) ||
                           (phase_reg == adsr_pkg::PH_SUSTAIN);
    assign stat.cnt_nz   = (cnt_reg != '0);
    assign stat.out_busy = out_busy;

    // restoring division, one quotient bit per step
    assign prod_c  = e_reg * mulk_reg;
    assign prod_hi = prod_reg[PB-1:QB];
    assign rem_try = {rem_reg, lo_reg[QB-1]};
    assign rem_ge  = (rem_try >= {1'b0, den_reg});
    assign rem_sub = rem_try - {1'b0, den_reg};

    // quotient clamped to full scale serves all three ramps
    assign qsat = (sat_reg || (quo_reg > QB'(adsr_pkg::FULL_SCALE)))
                ? LB'(adsr_pkg::FULL_SCALE) : quo_reg[LB-1:0];

    always_comb begin
        case (phase_reg)
            adsr_pkg::PH_ATTACK:  level_c = qsat;
            adsr_pkg::PH_DECAY:   level_c = LB'(adsr_pkg::FULL_SCALE) - qsat;
            adsr_pkg::PH_SUSTAIN: level_c = cfg.sustain_level;
            adsr_pkg::PH_RELEASE: level_c = (cfg.sustain_level > qsat)
                                          ? cfg.sustain_level - qsat : '0;
            default:              level_c = '0;
        endcase
    end

    // elapsed time saturates at all ones
    assign esum = {1'b0, e_reg} + (EB + 1)'(delta_reg);
    assign esat = esum[EB] ? '1 : esum[EB-1:0];

    always_comb begin
        phase_next = phase_reg;
        e_next     = e_reg;
        if (ctrl.fetch && s_valid) begin
            if (s_kind == adsr_pkg::KIND_ON) begin
                phase_next = adsr_pkg::PH_ATTACK;
                e_next     = '0;
            end else if (s_kind == adsr_pkg::KIND_OFF) begin
                phase_next = adsr_pkg::PH_RELEASE;
                e_next     = '0;
            end
        end else if (ctrl.adv) begin
            case (phase_reg)
                adsr_pkg::PH_ATTACK: begin
                    e_next = esat;
                    if (esat > {1'b0, den_reg}) begin
                        e_next     = esat - {1'b0, den_reg};
                        phase_next = adsr_pkg::PH_DECAY;
                    end
                end
                adsr_pkg::PH_DECAY: begin
                    e_next = esat;
                    if (esat > {1'b0, den_reg}) begin
                        e_next     = esat - {1'b0, den_reg};
                        phase_next = adsr_pkg::PH_SUSTAIN;
                    end
                end
                adsr_pkg::PH_RELEASE: begin
                    e_next = esat;
                    if (esat > {1'b0, den_reg}) begin
                        e_next     = '0;
                        phase_next = adsr_pkg::PH_IDLE;
                    end
                end
                adsr_pkg::PH_SUSTAIN: e_next = '0;
                default: begin
                    e_next     = '0;
                    phase_next = adsr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= adsr_pkg::PH_IDLE;
            e_reg     <= '0;
        end else begin
            phase_reg <= phase_next;
            e_reg     <= e_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.div_init) begin
            cnt_reg <= adsr_pkg::CNT_BITS'(QB - 1);
        end else if (ctrl.div_step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fetch && s_valid) begin
            // on and off requests ignore their time
            delta_reg <= (s_kind == adsr_pkg::KIND_ON || s_kind == adsr_pkg::KIND_OFF)
                       ? '0 : s_delta_time;
        end
        if (ctrl.sel) begin
            case (phase_reg)
                adsr_pkg::PH_ATTACK: begin
                    mulk_reg <= LB'(adsr_pkg::FULL_SCALE);
                    den_reg  <= cfg.attack_time;
                end
                adsr_pkg::PH_DECAY: begin
                    mulk_reg <= LB'(adsr_pkg::FULL_SCALE) - cfg.sustain_level;
                    den_reg  <= cfg.decay_time;
                end
                adsr_pkg::PH_RELEASE: begin
                    mulk_reg <= cfg.sustain_level;
                    den_reg  <= cfg.release_time;
                end
                default: begin
                    mulk_reg <= '0;
                    den_reg  <= cfg.attack_time;
                end
            endcase
        end
        if (ctrl.mul) begin
            prod_reg <= prod_c;
        end
        if (ctrl.div_init) begin
            // quotient does not fit when the upper part reaches the divisor
            sat_reg <= (prod_hi >= den_reg);
            rem_reg <= prod_hi;
            lo_reg  <= prod_reg[QB-1:0];
            quo_reg <= '0;
        end else if (ctrl.div_step) begin
            rem_reg <= rem_ge ? rem_sub[TB-1:0] : rem_try[TB-1:0];
            lo_reg  <= {lo_reg[QB-2:0], 1'b0};
            quo_reg <= {quo_reg[QB-2:0], rem_ge};
        end
        if (ctrl.level) begin
            level_reg <= level_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out && !out_busy) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out && !out_busy) begin
            m_level_reg    <= level_reg;
            m_sounding_reg <= (phase_reg != adsr_pkg::PH_IDLE);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_level    = m_level_reg;
    assign m_sounding = m_sounding_reg;

    `ASSERT_RST(a_cnt_range, cnt_reg <= adsr_pkg::CNT_BITS'(QB - 1),
        "divider count out of range")
    `ASSERT_IMPL(a_rem_below_den, ctrl.div_step && !sat_reg, rem_reg < den_reg,
        "partial remainder not below divisor")
    `ASSERT_IMPL(a_result_from_out, $rose(m_valid_reg), $past(ctrl.out),
        "result raised outside output step")
    `ASSERT_IMPL(a_ramp_bound,
        $past(ctrl.adv) && phase_reg == $past(phase_reg) &&
        (phase_reg == adsr_pkg::PH_ATTACK || phase_reg == adsr_pkg::PH_DECAY),
        e_reg <= {1'b0, den_reg}, "elapsed time past ramp length")

endmodule

`default_nettype wire

@@ hdl/adsr_envelope_generator.sv @@
// top level of the linear adsr envelope generator
// Usage:
//   Each request on the s_ channel is a tick (s_kind 0 or 3) carrying s_delta_time,
//   a note on (1) or a note off (2). Every request yields exactly one result on
//   the m_ channel: m_level, the Q1.15 level before the time advance (0..32768),
//   and m_sounding, set when the envelope is not idle after the step.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data;
//   zero times and sustain levels above full scale are ignored.
// Timing:
//   A small microprogram runs each request: fetch, operand select, multiply,
//   then a 17-step restoring divider, level and advance, output. Attack, decay
//   and release requests run every step; idle and sustain requests skip the
//   multiply and the divider.
//   One request is in work at a time; the next is taken the cycle after the
//   previous result is loaded into the output register.
// Reset and stall:
//   aresetn (synchronous, active low) clears the phase to idle, elapsed time to
//   zero, the registers to their defaults and drops m_valid. While m_ready is
//   low a pending result holds and the sequencer, on reaching its output step, waits there.
`default_nettype none

module adsr_envelope_generator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [adsr_pkg::KIND_BITS-1:0]      s_kind,
    input  wire logic [adsr_pkg::TIME_BITS-1:0]      s_delta_time,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [adsr_pkg::LEVEL_BITS-1:0]          m_level,
    output logic                                     m_sounding
);

    adsr_pkg::cfg_t     cfg;
    adsr_pkg::dp_ctrl_t ctrl;
    adsr_pkg::dp_stat_t stat;

    adsr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    adsr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .stat         (stat),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_delta_time (s_delta_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_level      (m_level),
        .m_sounding   (m_sounding)
    );

endmodule

`default_nettype wire
